FILE: src/assert_macros.svh
// Assertion helpers included by the top-level RTL file.
// Each macro takes a label, the clock, the active-low reset, the check and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: src/rnp_pkg.sv
package rnp_pkg;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT_NOTE,
        ST_EMIT_END
    } t_state;

    // Parse phases within one note.
    typedef enum logic [1:0] {
        PH_DUR,
        PH_PITCH,
        PH_SHARP,
        PH_OCT
    } t_phase;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DEF_DIV   = 2'd0,
        CFG_DEF_OCT   = 2'd1,
        CFG_FULL_NOTE = 2'd2,
        CFG_NONE      = 2'd3
    } t_cfg_index;

    localparam int          BASE_OCTAVE_DEF  = 4;
    localparam logic [5:0]  DEF_DIV_RESET    = 6'd4;
    localparam logic [3:0]  DEF_OCT_RESET    = 4'd6;
    localparam logic [15:0] FULL_NOTE_RESET  = 16'd3808;

    // Character codes.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SHARP = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_P     = 8'h70;

    localparam logic [3:0] IDX_NONE    = 4'd15;
    localparam logic [3:0] IDX_SHARP   = 4'd7;
    localparam logic [3:0] IDX_ENTRIES = 4'd14;

    // Fourth-octave tone table: naturals a-g, then their sharps (none for b and e).
    function automatic logic [15:0] tone_lookup(input logic [3:0] idx);
        logic [15:0] f;
        case (idx)
            4'd0:    f = 16'd220;
            4'd1:    f = 16'd247;
            4'd2:    f = 16'd262;
            4'd3:    f = 16'd294;
            4'd4:    f = 16'd330;
            4'd5:    f = 16'd349;
            4'd6:    f = 16'd392;
            4'd7:    f = 16'd233;
            4'd9:    f = 16'd277;
            4'd10:   f = 16'd311;
            4'd12:   f = 16'd370;
            4'd13:   f = 16'd415;
            default: f = 16'd0;
        endcase
        return f;
    endfunction

endpackage

FILE: src/rnp_divider.sv
// Restoring divider, one quotient bit per cycle.
module rnp_divider import rnp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [15:0] o_quotient
);

    logic [15:0] r_rem, n_rem;
    logic [15:0] r_quo, n_quo;
    logic [15:0] r_den;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [16:0] trial;
    logic [16:0] shifted;

    // One trial subtraction per step.
    always_comb begin
        shifted = {r_rem, r_quo[15]};
        trial   = shifted - {1'b0, r_den};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (r_busy) begin
            if (!trial[16]) begin
                n_rem = trial[15:0];
                n_quo = {r_quo[14:0], 1'b1};
            end else begin
                n_rem = shifted[15:0];
                n_quo = {r_quo[14:0], 1'b0};
            end
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: src/rtttl_note_parser_top.sv
// Channel   Direction  Handshake                 Word
// input     in         i_in_valid / o_in_ready   i_char_code
// result    out        o_out_valid / i_out_ready o_frequency_hz, o_duration_ms, o_end_of_song
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Characters that complete no note are taken back to back; the block stays ready.
// A comma or zero byte that completes a note starts the divider; after its 16 steps the quotient
// is latched on entry to ST_EMIT_NOTE, which loads the result word once the output is free.
// A zero byte enters ST_EMIT_END after the note word is loaded, or on acceptance when no note
// is pending; the end marker loads once the output is free, and only then is input ready again.
// Synchronous active-low reset restores register defaults and clears the parse state.
`include "assert_macros.svh"
module rtttl_note_parser_top import rnp_pkg::*; #(
    parameter int BASE_OCTAVE = BASE_OCTAVE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_frequency_hz,
    output logic [15:0] o_duration_ms,
    output logic        o_end_of_song,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [3:0] BaseOct = 4'(BASE_OCTAVE);

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [15:0] r_acc, n_acc;
    logic [3:0]  r_idx, n_idx;
    logic        r_rest, n_rest;
    logic        r_dot, n_dot;
    logic [3:0]  r_oct, n_oct;
    logic        r_pend, n_pend;
    logic        r_end_next, n_end_next;

    logic [5:0]  r_def_div;
    logic [3:0]  r_def_oct;
    logic [15:0] r_full_note;

    logic        r_out_valid, n_out_valid;
    logic [15:0] r_freq, n_freq;
    logic [15:0] r_dur, n_dur;
    logic        r_eos, n_eos;

    logic        in_acc;
    logic        out_free;
    logic        is_digit;
    logic [3:0]  digit_val;
    logic [15:0] divisor;
    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [15:0] quotient;
    logic [15:0] r_quot;
    logic [3:0]  oct_eff;
    logic [15:0] note_freq;
    logic [15:0] note_dur;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign is_digit    = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign digit_val   = i_char_code[3:0];

    // Divisor: accumulated digits, else the default, and never zero.
    always_comb begin
        divisor = (r_acc != 16'd0) ? r_acc : {10'd0, r_def_div};
        if (divisor == 16'd0) begin
            divisor = 16'd1;
        end
    end

    rnp_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_full_note),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // Note result from the held quotient and parse state.
    always_comb begin
        oct_eff   = (r_oct != 4'd0) ? r_oct : r_def_oct;
        note_freq = 16'd0;
        if (!r_rest && (r_idx < IDX_ENTRIES)) begin
            note_freq = tone_lookup(r_idx);
            if (oct_eff > BaseOct) begin
                note_freq = note_freq << (oct_eff - BaseOct);
            end
        end
        note_dur = r_dot ? (r_quot + {1'b0, r_quot[15:1]}) : r_quot;
    end

    // Sequencer and character parser.
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_idx       = r_idx;
        n_rest      = r_rest;
        n_dot       = r_dot;
        n_oct       = r_oct;
        n_pend      = r_pend;
        n_end_next  = r_end_next;
        n_out_valid = r_out_valid && !i_out_ready;
        n_freq      = r_freq;
        n_dur       = r_dur;
        n_eos       = r_eos;
        div_start   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_char_code == CH_NUL) begin
                        n_end_next = 1'b1;
                        if (r_pend) begin
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end else begin
                            n_state = ST_EMIT_END;
                        end
                    end else if (i_char_code == CH_COMMA) begin
                        n_end_next = 1'b0;
                        if (r_pend) begin
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end else begin
                            n_phase = PH_DUR;
                            n_acc   = '0;
                            n_idx   = '0;
                            n_rest  = 1'b0;
                            n_dot   = 1'b0;
                            n_oct   = '0;
                        end
                    end else if (i_char_code == CH_SPACE) begin
                        n_state = ST_IDLE;
                    end else if (r_phase == PH_DUR) begin
                        if (is_digit) begin
                            n_acc = {r_acc[12:0], 3'b000} + {r_acc[14:0], 1'b0}
                                  + {12'd0, digit_val};
                        end else begin
                            if (i_char_code == CH_P) begin
                                n_rest = 1'b1;
                                n_idx  = '0;
                            end else if ((i_char_code >= CH_A) && (i_char_code <= CH_G)) begin
                                n_rest = 1'b0;
                                n_idx  = 4'(i_char_code - CH_A);
                            end else begin
                                n_rest = 1'b0;
                                n_idx  = IDX_NONE;
                            end
                            n_pend  = 1'b1;
                            n_phase = PH_PITCH;
                        end
                    end else if (i_char_code == CH_SHARP) begin
                        if ((r_phase == PH_PITCH) && !r_rest) begin
                            if (r_idx < IDX_SHARP) begin
                                n_idx = r_idx + IDX_SHARP;
                            end
                            n_phase = PH_SHARP;
                        end
                    end else if (i_char_code == CH_DOT) begin
                        n_dot = 1'b1;
                        if (r_phase == PH_PITCH) begin
                            n_phase = PH_SHARP;
                        end
                    end else if (is_digit) begin
                        if (r_phase != PH_OCT) begin
                            n_oct   = digit_val;
                            n_phase = PH_OCT;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_EMIT_NOTE;
                end
            end
            ST_EMIT_NOTE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_freq      = note_freq;
                    n_dur       = note_dur;
                    n_eos       = 1'b0;
                    n_phase     = PH_DUR;
                    n_acc       = '0;
                    n_idx       = '0;
                    n_rest      = 1'b0;
                    n_dot       = 1'b0;
                    n_oct       = '0;
                    n_pend      = 1'b0;
                    n_state     = r_end_next ? ST_EMIT_END : ST_IDLE;
                end
            end
            ST_EMIT_END: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_freq      = '0;
                    n_dur       = '0;
                    n_eos       = 1'b1;
                    n_phase     = PH_DUR;
                    n_acc       = '0;
                    n_idx       = '0;
                    n_rest      = 1'b0;
                    n_dot       = 1'b0;
                    n_oct       = '0;
                    n_pend      = 1'b0;
                    n_end_next  = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_DUR;
            r_acc       <= '0;
            r_idx       <= '0;
            r_rest      <= 1'b0;
            r_dot       <= 1'b0;
            r_oct       <= '0;
            r_pend      <= 1'b0;
            r_end_next  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_idx       <= n_idx;
            r_rest      <= n_rest;
            r_dot       <= n_dot;
            r_oct       <= n_oct;
            r_pend      <= n_pend;
            r_end_next  <= n_end_next;
            r_out_valid <= n_out_valid;
        end
    end

    // Output word and captured quotient.
    always_ff @(posedge i_clk) begin
        r_freq <= n_freq;
        r_dur  <= n_dur;
        r_eos  <= n_eos;
        if (div_done) begin
            r_quot <= quotient;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_div   <= DEF_DIV_RESET;
            r_def_oct   <= DEF_OCT_RESET;
            r_full_note <= FULL_NOTE_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DEF_DIV:   r_def_div   <= i_cfg_data[5:0];
                CFG_DEF_OCT:   r_def_oct   <= i_cfg_data[3:0];
                CFG_FULL_NOTE: r_full_note <= i_cfg_data;
                CFG_NONE:      r_def_div   <= r_def_div;
                default:       r_def_div   <= r_def_div;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_frequency_hz = r_freq;
    assign o_duration_ms  = r_dur;
    assign o_end_of_song  = r_eos;

    // The divider never runs while a new character can be taken.
    `ASSERT_SAME(a_ready_div_idle, i_clk, i_rst_n, o_in_ready, !div_busy, "ready while dividing")
    // A zero byte always leads to a division or the end marker.
    `ASSERT_NEXT(a_nul_path, i_clk, i_rst_n, in_acc && (i_char_code == CH_NUL),
                 (r_state == ST_DIV) || (r_state == ST_EMIT_END), "zero byte lost")
    // Divider completion only happens while the sequencer waits for it.
    `ASSERT_SAME(a_done_in_div, i_clk, i_rst_n, div_done, r_state == ST_DIV, "stray divider done")
    // The end marker carries no tone.
    `ASSERT_SAME(a_end_word, i_clk, i_rst_n, o_out_valid && o_end_of_song,
                 (o_frequency_hz == 16'd0) && (o_duration_ms == 16'd0), "end marker not zero")

endmodule
